@@ rtl/floppy_rw_command_builder_assert.svh @@
// Assertion macros used by the floppy command builder RTL.
`ifndef FLOPPY_RW_COMMAND_BUILDER_ASSERT_SVH
`define FLOPPY_RW_COMMAND_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FCB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/fcb_pkg.sv @@
// Package with the types and constants of the floppy command builder.
`timescale 1ns / 1ps
`default_nettype none

package fcb_pkg;

   // Width of a logical block number.
   localparam int BLOCK_BITS = 16;

   // Divisors are at most sectors per track times head count (189).
   localparam int DIVISOR_W = 8;
   localparam int DIV_CNT_W = $clog2(BLOCK_BITS);

   // Request queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTORS  = 3'd0,
      CSR_HEADS    = 3'd1,
      CSR_READ_OP  = 3'd2,
      CSR_WRITE_OP = 3'd3,
      CSR_GAP      = 3'd4
   } fcb_csr_type;

   // Reset values of the configuration registers.
   localparam logic [5:0] SECTORS_RESET  = 6'd18;
   localparam logic [1:0] HEADS_RESET    = 2'd2;
   localparam logic [7:0] READ_OP_RESET  = 8'd230;
   localparam logic [7:0] WRITE_OP_RESET = 8'd197;
   localparam logic [7:0] GAP_RESET      = 8'd27;

   // Fixed bytes of the command packet.
   localparam logic [7:0] SIZE_CODE = 8'd2;
   localparam logic [7:0] PAD_BYTE  = 8'hff;

   // One queued request, already resolved to its opcode.
   typedef struct packed {
      logic [7:0]            opcode;
      logic [BLOCK_BITS-1:0] block;
   } fcb_item_type;

   // Disk geometry seen by the back part.
   typedef struct packed {
      logic [5:0] sectors;
      logic [1:0] heads;
      logic [7:0] gap;
   } fcb_geom_type;

endpackage

`default_nettype wire

@@ rtl/fcb_front.sv @@
// Front part: configuration registers, request intake and the request queue.
`timescale 1ns / 1ps
`default_nettype none

module fcb_front import fcb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic [BLOCK_BITS-1:0]  req_block,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output fcb_geom_type                geom,
   output logic                        q_valid,
   output fcb_item_type                q_item,
   input  wire logic                   q_pop
);

   logic [5:0]   sectors_ff;
   logic [1:0]   heads_ff;
   logic [7:0]   read_op_ff;
   logic [7:0]   write_op_ff;
   logic [7:0]   gap_ff;

   fcb_item_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   fcb_item_type      new_item;

   // Configuration words are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff  <= SECTORS_RESET;
         heads_ff    <= HEADS_RESET;
         read_op_ff  <= READ_OP_RESET;
         write_op_ff <= WRITE_OP_RESET;
         gap_ff      <= GAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SECTORS:  sectors_ff  <= csr_data[5:0];
            CSR_HEADS:    heads_ff    <= csr_data[1:0];
            CSR_READ_OP:  read_op_ff  <= csr_data;
            CSR_WRITE_OP: write_op_ff <= csr_data;
            CSR_GAP:      gap_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign geom = '{sectors: sectors_ff, heads: heads_ff, gap: gap_ff};

   // Classify the request: a write takes the write opcode, a read the read opcode.
   always_comb begin
      new_item.opcode = req_action ? write_op_ff : read_op_ff;
      new_item.block  = req_block;
   end

   assign busy    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fcb_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fcb_div import fcb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [BLOCK_BITS-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic [BLOCK_BITS-1:0]      quotient,
   output logic [BLOCK_BITS-1:0]      remainder,
   output logic                       done
);

   logic [BLOCK_BITS-1:0] quo_ff;
   logic [BLOCK_BITS-1:0] rem_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [BLOCK_BITS:0]   trial;
   logic [BLOCK_BITS:0]   diff;
   logic                  fits;
   logic [BLOCK_BITS-1:0] rem_in;
   logic [BLOCK_BITS-1:0] quo_in;

   // One restoring step. A zero divisor always fits, which gives an all-ones
   // quotient and leaves the dividend as the remainder.
   always_comb begin
      trial  = {rem_ff, quo_ff[BLOCK_BITS-1]};
      diff   = trial - (BLOCK_BITS + 1)'(divisor_ff);
      fits   = (trial >= (BLOCK_BITS + 1)'(divisor_ff));
      rem_in = fits ? diff[BLOCK_BITS-1:0] : trial[BLOCK_BITS-1:0];
      quo_in = {quo_ff[BLOCK_BITS-2:0], fits};
   end

   // Control: run for BLOCK_BITS steps, then hold the result until the next start.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DIV_CNT_W'(BLOCK_BITS - 1);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

@@ rtl/fcb_back.sv @@
// Back part: geometry division and emission of the nine command bytes.
`timescale 1ns / 1ps
`default_nettype none

`include "floppy_rw_command_builder_assert.svh"

module fcb_back import fcb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fcb_geom_type geom,
   input  wire logic         q_valid,
   input  wire fcb_item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_cmd_byte,
   output logic              rsp_last
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   typedef enum logic [3:0] {
      BYTE_OPCODE,
      BYTE_HEAD_SEL,
      BYTE_TRACK,
      BYTE_HEAD,
      BYTE_SECTOR,
      BYTE_SIZE,
      BYTE_EOT,
      BYTE_GAP,
      BYTE_PAD
   } byte_pos_type;

   div_state_type         div_state_ff;
   div_state_type         div_state_in;
   logic [7:0]            opcode_ff;

   logic                  emit_active_ff;
   byte_pos_type          byte_ff;
   logic [7:0]            emit_opcode_ff;
   logic [7:0]            emit_head_ff;
   logic [7:0]            emit_track_ff;
   logic [7:0]            emit_sector_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_cmd_byte_ff;
   logic                  rsp_last_ff;
   logic [7:0]            byte_in;

   logic [DIVISOR_W-1:0]  cyl_size;
   logic [DIVISOR_W-1:0]  sectors_x2;
   logic [BLOCK_BITS-1:0] q_cyl;
   logic [BLOCK_BITS-1:0] r_cyl;
   logic [BLOCK_BITS-1:0] q_sec;
   logic [BLOCK_BITS-1:0] r_sec;
   logic                  done_c;
   logic                  done_s;
   logic [BLOCK_BITS-1:0] head_full;
   logic                  emit_free;
   logic                  result_ready;
   logic                  load_go;
   logic                  start_div;

   // Cylinder size fits in eight bits (at most 63 times 3).
   always_comb begin
      cyl_size   = DIVISOR_W'({2'b00, geom.sectors} * {6'd0, geom.heads});
      sectors_x2 = {1'b0, geom.sectors, 1'b0};
   end

   // Track and cylinder remainder from block / cylinder size.
   fcb_div u_div_cyl (
      .clock     (clock),
      .reset     (reset),
      .start     (start_div),
      .dividend  (q_item.block),
      .divisor   (cyl_size),
      .quotient  (q_cyl),
      .remainder (r_cyl),
      .done      (done_c)
   );

   // Sector from block mod sectors per track; the quotient serves a zero cylinder.
   fcb_div u_div_sec (
      .clock     (clock),
      .reset     (reset),
      .start     (start_div),
      .dividend  (q_item.block),
      .divisor   ({2'b00, geom.sectors}),
      .quotient  (q_sec),
      .remainder (r_sec),
      .done      (done_s)
   );

   // Head: the cylinder remainder is below three tracks, so two compares pick it.
   // With a zero cylinder size the remainder is the whole block, and the head is
   // the block divided by sectors per track.
   always_comb begin
      if (cyl_size == '0) begin
         head_full = q_sec;
      end else if (r_cyl[7:0] >= sectors_x2) begin
         head_full = BLOCK_BITS'(2);
      end else if (r_cyl[7:0] >= {2'b00, geom.sectors}) begin
         head_full = BLOCK_BITS'(1);
      end else begin
         head_full = '0;
      end
   end

   // Hand-off between the divider and the byte emitter.
   always_comb begin
      emit_free    = !emit_active_ff || (byte_ff == BYTE_PAD);
      result_ready = ((div_state_ff == DIV_RUN) && done_c) || (div_state_ff == DIV_HOLD);
      load_go      = result_ready && emit_free;
      start_div    = q_valid && ((div_state_ff == DIV_IDLE) || load_go);
      q_pop        = start_div;
   end

   always_comb begin
      div_state_in = div_state_ff;
      unique case (div_state_ff)
         DIV_IDLE: begin
            if (start_div) begin
               div_state_in = DIV_RUN;
            end
         end
         DIV_RUN, DIV_HOLD: begin
            if (result_ready) begin
               if (load_go) begin
                  div_state_in = start_div ? DIV_RUN : DIV_IDLE;
               end else begin
                  div_state_in = DIV_HOLD;
               end
            end
         end
         default: div_state_in = DIV_IDLE;
      endcase
   end

   // Byte selection for the current packet position.
   always_comb begin
      unique case (byte_ff)
         BYTE_OPCODE:   byte_in = emit_opcode_ff;
         BYTE_HEAD_SEL: byte_in = {emit_head_ff[5:0], 2'b00};
         BYTE_TRACK:    byte_in = emit_track_ff;
         BYTE_HEAD:     byte_in = emit_head_ff;
         BYTE_SECTOR:   byte_in = emit_sector_ff;
         BYTE_SIZE:     byte_in = SIZE_CODE;
         BYTE_EOT:      byte_in = {2'b00, geom.sectors};
         BYTE_GAP:      byte_in = geom.gap;
         BYTE_PAD:      byte_in = PAD_BYTE;
         default:       byte_in = PAD_BYTE;
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff   <= DIV_IDLE;
         emit_active_ff <= 1'b0;
         byte_ff        <= BYTE_OPCODE;
         rsp_valid_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         div_state_ff <= div_state_in;
         rsp_valid_ff <= emit_active_ff;
         rsp_last_ff  <= emit_active_ff && (byte_ff == BYTE_PAD);
         if (load_go) begin
            emit_active_ff <= 1'b1;
            byte_ff        <= BYTE_OPCODE;
         end else if (emit_active_ff && (byte_ff == BYTE_PAD)) begin
            emit_active_ff <= 1'b0;
            byte_ff        <= BYTE_OPCODE;
         end else if (emit_active_ff) begin
            byte_ff <= byte_pos_type'(byte_ff + 4'd1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_cmd_byte_ff <= byte_in;
      if (start_div) begin
         opcode_ff <= q_item.opcode;
      end
      if (load_go) begin
         emit_opcode_ff <= opcode_ff;
         emit_head_ff   <= head_full[7:0];
         emit_track_ff  <= q_cyl[7:0];
         emit_sector_ff <= r_sec[7:0] + 8'd1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cmd_byte = rsp_cmd_byte_ff;
   assign rsp_last     = rsp_last_ff;

   `FCB_ASSERT_NOW(a_hold_has_result, clock, reset, div_state_ff == DIV_HOLD, done_c)
   `FCB_ASSERT_NOW(a_dividers_in_step, clock, reset, 1'b1, done_c == done_s)
   `FCB_ASSERT_NEXT(a_load_starts_packet, clock, reset, load_go, emit_active_ff && byte_ff == BYTE_OPCODE)

endmodule

`default_nettype wire

@@ rtl/floppy_rw_command_builder.sv @@
// Top level of the floppy read/write command builder.
`timescale 1ns / 1ps
`default_nettype none

// A request (action, block) is taken when start is high and busy is low; up to two
// requests wait in a queue while an earlier one is being worked on. Each request
// produces nine command bytes on consecutive cycles, each shown for one cycle with
// rsp_valid, the ninth marked by rsp_last. The receiver cannot stall the output, so
// it must take every byte in the cycle it appears. The block number is split into
// track, head and sector by two serial dividers that retire one quotient bit per
// cycle, then hand the result to the byte emitter; byte emission overlaps the next
// division. Configuration words are always accepted and should be written only
// while no request is in flight.
module floppy_rw_command_builder import fcb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic [BLOCK_BITS-1:0]  req_block,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_cmd_byte,
   output logic                        rsp_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   fcb_geom_type geom;
   logic         q_valid;
   fcb_item_type q_item;
   logic         q_pop;

   // Intake, configuration and request queue.
   fcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_block  (req_block),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .geom       (geom),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Division and command byte emission.
   fcb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .geom         (geom),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_cmd_byte (rsp_cmd_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
